/* hdl/dtic_pkg.sv */
// Package for the decimal text to integer converter with range check.
// Holds character codes, register indexes and the parser position type.
// No dependencies.
`timescale 1ns / 1ps

package dtic_pkg;

    // Width of the value path and of the range registers.
    localparam int unsigned DATA_W = 32;

    // ASCII codes that the parser recognizes.
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_SIGNED_MODE    = 2'd0,
        REG_SIGNED_MIN     = 2'd1,
        REG_SIGNED_MAX     = 2'd2,
        REG_UNSIGNED_LIMIT = 2'd3
    } reg_index_t;

    // Where the parser stands within the current string.
    typedef enum logic [2:0] {
        POS_START  = 3'b001,
        POS_SIGN   = 3'b010,
        POS_DIGITS = 3'b100
    } position_t;

endpackage

/* hdl/decimal_text_to_int_range_check.sv */
// Top level of the decimal text to integer converter with range check.
// Depends on dtic_pkg for character codes, register indexes and types.
`timescale 1ns / 1ps

// Usage:
// Characters enter on the s_ channel, one per request. A zero byte ends a
// string and produces exactly one request on the m_ channel carrying m_ok and
// m_result_value; other characters produce nothing. Each character is first
// captured in an input register and is processed from there, where the overflow
// check (magnitude times ten plus digit against the limit) and the state update
// happen; a terminator writes the output register in that cycle. A result passes
// the input register and then the output register before m_valid rises, and one
// character is taken every cycle while no terminator waits. When the receiver
// stalls with a result pending, digits keep flowing; only a second terminator
// waits in the input register until the output register is taken, which then
// holds s_ready low. The configuration channel is always ready; the user must
// write it only between strings, which the block itself does not enforce. Reset
// (aresetn low, synchronous) empties both registers, returns the parser to the
// string start and loads the default range: signed mode, full 32-bit signed range and full unsigned limit.
module decimal_text_to_int_range_check
    import dtic_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [DATA_W-1:0] cfg_data,

    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_character,

    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_ok,
    output logic [DATA_W-1:0] m_result_value
);

    // Configuration registers.
    logic              signed_mode_reg;
    logic [DATA_W-1:0] signed_min_reg;
    logic [DATA_W-1:0] signed_max_reg;
    logic [DATA_W-1:0] unsigned_limit_reg;

    // Input register.
    logic              in_valid_reg;
    logic [7:0]        in_char_reg;

    // Parser state.
    position_t         pos_reg,    pos_next;
    logic              neg_reg,    neg_next;
    logic              failed_reg, failed_next;
    logic [DATA_W-1:0] mag_reg,    mag_next;

    // Output register.
    logic              m_valid_reg;
    logic              m_ok_reg,    m_ok_next;
    logic [DATA_W-1:0] m_value_reg, m_value_next;

    logic              is_term;
    logic              advance;
    logic              is_digit;
    logic              is_sign;
    logic [3:0]        digit;
    logic [DATA_W-1:0] limit;
    logic [DATA_W+3:0] scaled;
    logic              overflow;
    logic signed [DATA_W+1:0] lo_ext;
    logic signed [DATA_W+1:0] hi_ext;
    logic signed [DATA_W+1:0] value_ext;
    logic              in_range;

    assign cfg_ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            signed_mode_reg    <= 1'b1;
            signed_min_reg     <= {1'b1, {(DATA_W-1){1'b0}}};
            signed_max_reg     <= {1'b0, {(DATA_W-1){1'b1}}};
            unsigned_limit_reg <= {DATA_W{1'b1}};
        end else if (cfg_valid && cfg_ready) begin
            case (reg_index_t'(cfg_index))
                REG_SIGNED_MODE:    signed_mode_reg    <= cfg_data[0];
                REG_SIGNED_MIN:     signed_min_reg     <= cfg_data;
                REG_SIGNED_MAX:     signed_max_reg     <= cfg_data;
                REG_UNSIGNED_LIMIT: unsigned_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake: a terminator can only move on when the output register is free.
    assign is_term = (in_char_reg == CHAR_NUL);
    assign advance = in_valid_reg && (!is_term || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_character;
        end
    end

    // Character classification.
    always_comb begin
        is_digit = in_char_reg inside {[CHAR_ZERO:CHAR_NINE]};
        is_sign  = (in_char_reg == CHAR_PLUS) || (in_char_reg == CHAR_MINUS);
        digit    = in_char_reg[3:0];
    end

    // Magnitude limit for the next digit, chosen by mode and sign.
    always_comb begin
        if (!signed_mode_reg) begin
            limit = unsigned_limit_reg;
        end else if (neg_reg) begin
            limit = signed_min_reg[DATA_W-1] ? (~signed_min_reg + 1'b1) : '0;
        end else begin
            limit = (!signed_max_reg[DATA_W-1] && (signed_max_reg != '0)) ?
                    signed_max_reg : '0;
        end
    end

    // Ten times the magnitude plus the digit, four bits wider than the value.
    // Exceeding the limit here is the same as the quotient/remainder test.
    always_comb begin
        scaled   = ({4'b0, mag_reg} << 3) + ({4'b0, mag_reg} << 1) + {{DATA_W{1'b0}}, digit};
        overflow = scaled > {4'b0, limit};
    end

    // Signed range check at the terminator.
    always_comb begin
        lo_ext    = {{2{signed_min_reg[DATA_W-1]}}, signed_min_reg};
        hi_ext    = {{2{signed_max_reg[DATA_W-1]}}, signed_max_reg};
        value_ext = neg_reg ? -$signed({2'b00, mag_reg}) : $signed({2'b00, mag_reg});
        in_range  = (lo_ext <= hi_ext) && (value_ext >= lo_ext) && (value_ext <= hi_ext);
    end

    // Next parser state and result.
    always_comb begin
        pos_next     = pos_reg;
        neg_next     = neg_reg;
        failed_next  = failed_reg;
        mag_next     = mag_reg;
        m_ok_next    = 1'b0;
        m_value_next = '0;
        if (is_term) begin
            if (!failed_reg && (pos_reg == POS_DIGITS)) begin
                if (signed_mode_reg) begin
                    if (in_range) begin
                        m_ok_next    = 1'b1;
                        m_value_next = value_ext[DATA_W-1:0];
                    end
                end else if (!neg_reg && (mag_reg <= unsigned_limit_reg)) begin
                    m_ok_next    = 1'b1;
                    m_value_next = mag_reg;
                end
            end
            pos_next    = POS_START;
            neg_next    = 1'b0;
            failed_next = 1'b0;
            mag_next    = '0;
        end else if (!failed_reg) begin
            if (is_digit) begin
                if (overflow) begin
                    failed_next = 1'b1;
                end else begin
                    mag_next = scaled[DATA_W-1:0];
                    pos_next = POS_DIGITS;
                end
            end else if (signed_mode_reg && (pos_reg == POS_START) && is_sign) begin
                neg_next = (in_char_reg == CHAR_MINUS);
                pos_next = POS_SIGN;
            end else begin
                failed_next = 1'b1;
            end
        end
    end

    // Parser state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= POS_START;
            neg_reg    <= 1'b0;
            failed_reg <= 1'b0;
            mag_reg    <= '0;
        end else if (advance) begin
            pos_reg    <= pos_next;
            neg_reg    <= neg_next;
            failed_reg <= failed_next;
            mag_reg    <= mag_next;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && is_term) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && is_term) begin
            m_ok_reg    <= m_ok_next;
            m_value_reg <= m_value_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_ok           = m_ok_reg;
    assign m_result_value = m_value_reg;

`ifndef ASSERT_OFF
    // A rejected string always reports a zero value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ok_reg |-> m_value_reg == '0)
        else $error("result value not zero on a rejected string");

    // A processed terminator always loads the output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && is_term |=> m_valid_reg)
        else $error("terminator processed without a result");

    // At the string start no digits or sign have been taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg == POS_START |-> mag_reg == '0 && !neg_reg)
        else $error("parser state not clear at string start");

    // A waiting terminator never overwrites a result that is still held.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready && in_valid_reg && is_term |-> !advance)
        else $error("pending result overwritten");
`endif

endmodule

/* bench/conversion_checker.sv */
// Checker for the decimal text to integer converter: watches the register, character and
// result channels, predicts each conversion and compares it with what the block returns.
// Depends on dtic_pkg for character codes, register indexes and the parser position type.
`timescale 1ns / 1ps

module conversion_checker
    import dtic_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [DATA_W-1:0] cfg_data,

    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [7:0]        s_character,

    input  logic              m_valid,
    input  logic              m_ready,
    input  logic              m_ok,
    input  logic [DATA_W-1:0] m_result_value,

    output int unsigned       error_count,
    output int unsigned       outstanding
);

    typedef struct packed {
        logic              ok;
        logic [DATA_W-1:0] value;
    } conversion_t;

    // Conversions predicted from accepted terminators, oldest first.
    conversion_t predicted_conversions[$];

    // Shadow copy of the range registers.
    logic                     mode_reg;
    logic signed [DATA_W-1:0] min_reg;
    logic signed [DATA_W-1:0] max_reg;
    logic [DATA_W-1:0]        limit_reg;

    // Shadow copy of the parser state for the current string.
    logic              negative;
    logic [DATA_W-1:0] magnitude;
    position_t         position;
    logic              failed;

    task automatic note_error(input string what);
        error_count++;
        if (error_count <= 10) begin
            $display("%0t ns: %s", $time, what);
        end
    endtask

    task automatic clear_string();
        negative  = 1'b0;
        magnitude = '0;
        position  = POS_START;
        failed    = 1'b0;
    endtask

    // Largest magnitude the current string may reach before the next digit.
    function automatic longint digit_limit(input longint lo, input longint hi);
        if (!mode_reg) begin
            return longint'(limit_reg);
        end
        if (negative) begin
            return (lo < 0) ? -lo : 64'sd0;
        end
        return (hi > 0) ? hi : 64'sd0;
    endfunction

    // Advance the parser by one character; a terminator yields a predicted conversion.
    task automatic parse_character(input logic [7:0] ch);
        longint      lo;
        longint      hi;
        longint      lim;
        longint      digit;
        longint      v;
        conversion_t res;
        lo = longint'(min_reg);
        hi = longint'(max_reg);
        if (ch == CHAR_NUL) begin
            res = '0;
            if (!failed && position == POS_DIGITS) begin
                if (mode_reg) begin
                    v = negative ? -longint'(magnitude) : longint'(magnitude);
                    if (lo <= hi && v >= lo && v <= hi) begin
                        res.ok    = 1'b1;
                        res.value = v[DATA_W-1:0];
                    end
                end else if (!negative && magnitude <= limit_reg) begin
                    res.ok    = 1'b1;
                    res.value = magnitude;
                end
            end
            predicted_conversions.push_back(res);
            clear_string();
        end else if (!failed) begin
            if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
                // Reject the digit if it would carry the magnitude past the limit.
                digit = longint'(ch) - longint'(CHAR_ZERO);
                lim   = digit_limit(lo, hi);
                if (longint'(magnitude) > lim / 10 ||
                    (longint'(magnitude) == lim / 10 && digit > lim % 10)) begin
                    failed = 1'b1;
                end else begin
                    v         = longint'(magnitude) * 10 + digit;
                    magnitude = v[DATA_W-1:0];
                    position  = POS_DIGITS;
                end
            end else if (mode_reg && position == POS_START &&
                         (ch == CHAR_PLUS || ch == CHAR_MINUS)) begin
                negative = (ch == CHAR_MINUS);
                position = POS_SIGN;
            end else begin
                failed = 1'b1;
            end
        end
    endtask

    task automatic compare_result();
        conversion_t want;
        if (predicted_conversions.size() == 0) begin
            note_error($sformatf("result with none pending: ok=%0b value=%h",
                                 m_ok, m_result_value));
        end else begin
            want = predicted_conversions.pop_front();
            if (m_ok !== want.ok || m_result_value !== want.value) begin
                note_error($sformatf("result differs: expected ok=%0b value=%h, got ok=%0b value=%h",
                                     want.ok, want.value, m_ok, m_result_value));
            end
        end
    endtask

    // Results are retired before new characters so a request never meets its own prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  = 1'b1;
            min_reg   = 32'sh8000_0000;
            max_reg   = 32'sh7FFF_FFFF;
            limit_reg = 32'hFFFF_FFFF;
            clear_string();
            predicted_conversions.delete();
        end else begin
            if (m_valid && m_ready) begin
                compare_result();
            end
            if (cfg_valid && cfg_ready) begin
                case (reg_index_t'(cfg_index))
                    REG_SIGNED_MODE:    mode_reg  = cfg_data[0];
                    REG_SIGNED_MIN:     min_reg   = cfg_data;
                    REG_SIGNED_MAX:     max_reg   = cfg_data;
                    REG_UNSIGNED_LIMIT: limit_reg = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                parse_character(s_character);
            end
        end
        outstanding = predicted_conversions.size();
    end

endmodule

/* bench/tb_top.sv */
// Top of the converter testbench: clock, reset, register writes and character stimulus.
// Depends on dtic_pkg, the decimal_text_to_int_range_check block and conversion_checker.
`timescale 1ns / 1ps

module tb_top;
    import dtic_pkg::*;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              cfg_valid   = 1'b0;
    logic              cfg_ready;
    reg_index_t        cfg_index   = REG_SIGNED_MODE;
    logic [DATA_W-1:0] cfg_data    = '0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    logic [7:0]        s_character = CHAR_NUL;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    logic              m_ok;
    logic [DATA_W-1:0] m_result_value;

    int unsigned error_count;
    int unsigned outstanding;

    // Stimulus state: the range in force, used only to aim numbers at the limits.
    bit                       quiet      = 1'b0;
    int unsigned              chars_sent = 0;
    int unsigned              stall_left = 0;
    bit                       mode_cfg;
    logic signed [DATA_W-1:0] min_cfg;
    logic signed [DATA_W-1:0] max_cfg;
    logic [DATA_W-1:0]        limit_cfg;

    decimal_text_to_int_range_check dut (.*);

    conversion_checker u_checker (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Give up if the run hangs.
    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        if (r < 98) begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(20, 60);
    endfunction

    // Result side stalls at random.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
            end
        end
    end

    // One character request; valid stays up when the next one follows at once.
    task automatic send_char(input logic [7:0] ch);
        int unsigned gap;
        s_valid     <= 1'b1;
        s_character <= ch;
        do @(posedge aclk); while (!s_ready);
        chars_sent++;
        @(negedge aclk);
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic send_string(input string txt);
        for (int i = 0; i < txt.len(); i++) begin
            send_char(txt[i]);
        end
        send_char(CHAR_NUL);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    task automatic configure(input bit mode, input logic signed [DATA_W-1:0] lo,
                             input logic signed [DATA_W-1:0] hi,
                             input logic [DATA_W-1:0] lim);
        mode_cfg  = mode;
        min_cfg   = lo;
        max_cfg   = hi;
        limit_cfg = lim;
        write_reg(REG_SIGNED_MODE, DATA_W'(mode));
        write_reg(REG_SIGNED_MIN, lo);
        write_reg(REG_SIGNED_MAX, hi);
        write_reg(REG_UNSIGNED_LIMIT, lim);
        cfg_valid <= 1'b0;
    endtask

    // Hold the sender until every conversion is back and the pipeline has emptied.
    task automatic settle();
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_bound();
        int s;
        case ($urandom_range(0, 6))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return 0;
            3: return -1;
            4: return 1;
            5: return $urandom;
            default: begin
                s = int'($urandom_range(0, 2000)) - 1000;
                return s;
            end
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_limit();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            3: return $urandom_range(0, 1000);
            default: return $urandom_range(0, 9);
        endcase
    endfunction

    task automatic configure_random();
        logic signed [DATA_W-1:0] lo;
        logic signed [DATA_W-1:0] hi;
        logic signed [DATA_W-1:0] t;
        lo = pick_bound();
        hi = pick_bound();
        // Keep an inverted range rare so that most strings can pass.
        if (lo > hi && $urandom_range(0, 5) != 0) begin
            t  = lo;
            lo = hi;
            hi = t;
        end
        configure($urandom_range(0, 3) != 0, lo, hi, pick_limit());
    endtask

    // A well-formed number, often aimed right at the limit that applies to it.
    task automatic send_number();
        string  sign_txt;
        string  zeros;
        bit     neg;
        longint lim;
        longint mag;
        sign_txt = "";
        zeros    = "";
        neg      = 1'b0;
        if (mode_cfg || $urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
                0: sign_txt = "+";
                1: begin
                    sign_txt = "-";
                    neg      = 1'b1;
                end
                default: ;
            endcase
        end
        if (!mode_cfg) begin
            lim = longint'(limit_cfg);
        end else begin
            lim = neg ? -longint'(min_cfg) : longint'(max_cfg);
        end
        if (lim < 0) begin
            lim = 0;
        end
        case ($urandom_range(0, 4))
            0: mag = lim + longint'($urandom_range(0, 4)) - 2;
            1: mag = $urandom_range(0, 9);
            2: mag = longint'($urandom);
            3: mag = longint'($urandom) % (lim + 1);
            default: mag = 64'sd4294967296 + longint'($urandom_range(0, 9999));
        endcase
        if (mag < 0) begin
            mag = 0;
        end
        if ($urandom_range(0, 7) == 0) begin
            zeros = "00";
        end
        send_string({sign_txt, zeros, $sformatf("%0d", mag)});
    endtask

    // Arbitrary bytes, weighted toward digits and signs, then a terminator.
    task automatic send_noise();
        int unsigned n;
        n = $urandom_range(0, 6);
        repeat (n) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: send_char(8'($urandom_range(1, 255)));
                5, 6, 7:       send_char(8'($urandom_range(CHAR_ZERO, CHAR_NINE)));
                8:             send_char(CHAR_PLUS);
                default:       send_char(CHAR_MINUS);
            endcase
        end
        send_char(CHAR_NUL);
    endtask

    initial begin
        int unsigned phase;
        int unsigned count;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset range: empty string, lone sign, plus sign, misplaced sign, junk.
        send_string("");
        send_string("-");
        send_string("+7");
        send_string("1-");
        send_char(8'hFF);
        send_string("9");
        settle();

        // Narrow signed range: overflow below the minimum, the minimum, overflow above.
        write_reg(REG_SIGNED_MIN, -5);
        write_reg(REG_SIGNED_MAX, 9);
        cfg_valid <= 1'b0;
        send_string("-6");
        send_string("-5");
        send_string("10");
        settle();

        // Unsigned mode rejects a sign and anything past the limit.
        write_reg(REG_SIGNED_MODE, '0);
        write_reg(REG_UNSIGNED_LIMIT, 7);
        cfg_valid <= 1'b0;
        send_string("+1");
        send_string("8");
        settle();

        // A minus taken in signed mode stays with the string after a switch to unsigned.
        write_reg(REG_SIGNED_MODE, 1);
        cfg_valid <= 1'b0;
        send_char(CHAR_MINUS);
        settle();
        write_reg(REG_SIGNED_MODE, '0);
        cfg_valid <= 1'b0;
        send_string("3");
        settle();

        // Minimum above maximum never passes.
        write_reg(REG_SIGNED_MODE, 1);
        write_reg(REG_SIGNED_MIN, 3);
        write_reg(REG_SIGNED_MAX, 2);
        cfg_valid <= 1'b0;
        send_string("2");
        settle();

        // Random phases, each with its own range and a drain at the end.
        phase = 0;
        while (chars_sent < 1460) begin
            case (phase)
                0: configure(1'b1, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
                1: configure(1'b0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
                2: configure(1'b0, 0, 0, '0);
                3: configure(1'b1, 0, 0, '0);
                default: configure_random();
            endcase
            quiet = ($urandom_range(0, 4) == 0);
            count = $urandom_range(5, 30);
            repeat (count) begin
                if ($urandom_range(0, 4) != 0) begin
                    send_number();
                end else begin
                    send_noise();
                end
            end
            settle();
            quiet = 1'b0;
            phase++;
        end

        settle();
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/dtic_pkg.sv
hdl/decimal_text_to_int_range_check.sv
bench/conversion_checker.sv
bench/tb_top.sv
